// ===== design/value_stack_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the value stack with search
// Concurrent assertion helpers, sampled on clk_i and, where named, held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VALUE_STACK_WITH_SEARCH_ASSERT_SVH
`define VALUE_STACK_WITH_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside of reset.
`define VSWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define VSWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define VSWS_ASSERT(lbl, prop, msg)
`define VSWS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/vsws_pkg.sv =====
// ----------------------------------------------------------------------------
// Value stack with search: package
// Sizes, operation and status codes, and the transfer and cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsws_pkg;

  // Number of cells in the row.
  localparam int StackDepth = 16;
  // Width of the entry counter, wide enough to hold StackDepth itself.
  localparam int CountW = $clog2(StackDepth + 1);
  // Width of a stored value.
  localparam int ValueW = 16;
  // Width of the reported occupancy field.
  localparam int OccW = 5;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpPop    = 2'd1,
    OpSearch = 2'd2,
    OpRemove = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef logic signed [ValueW-1:0] value_t;

  // One request transfer.
  typedef struct packed {
    opcode_e opcode;
    value_t  value;
  } req_t;

  // One result transfer.
  typedef struct packed {
    value_t          result_value;
    status_e         status;
    logic            found;
    logic            now_empty;
    logic [OccW-1:0] occupancy;
  } rsp_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic   push;
    logic   pop;
    logic   remove;
    value_t value;
  } cell_ctrl_t;

endpackage

// ===== design/vsws_cell.sv =====
// ----------------------------------------------------------------------------
// Value stack cell
// Holds one entry, compares it with the request value, and shifts toward or
// away from the top of the row as the broadcast control directs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsws_cell (
  input  logic                clk_i,
  input  vsws_pkg::cell_ctrl_t ctrl_i,
  input  logic                live_i,
  input  vsws_pkg::value_t    above_data_i,
  input  vsws_pkg::value_t    below_data_i,
  input  logic                hit_above_i,
  output logic                hit_o,
  output vsws_pkg::value_t    data_o
);

  vsws_pkg::value_t data_q;
  vsws_pkg::value_t data_d;
  logic             match;

  // A held entry equal to the request value.
  assign match = live_i && (data_q == ctrl_i.value);

  // The hit chain marks this cell and every cell below the topmost match.
  assign hit_o = hit_above_i | match;

  // Push moves entries away from the top; pop and remove pull them back up.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = above_data_i;
    end else if (ctrl_i.pop) begin
      data_d = below_data_i;
    end else if (ctrl_i.remove && hit_o) begin
      data_d = below_data_i;
    end
  end

  // Entry storage carries no reset; the counter decides what is live.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/value_stack_with_search.sv =====
// The result of an accepted request is strobed on done_o in the next cycle.
// Throughput: one request per cycle; busy stays low, since the whole cell row
// compares in the cycle of each transfer and shifts as that transfer is taken.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the stack and clears done_o;
// stored entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Value stack with search: top level
// Bounded last-in-first-out store built as a row of cells with the top at
// cell 0. Supports push, pop, search and removal of the topmost match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "value_stack_with_search_assert.svh"

module value_stack_with_search (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vsws_pkg::req_t  req_i,
  output logic            done_o,
  output vsws_pkg::rsp_t  rsp_o
);

  logic [vsws_pkg::CountW-1:0] count_q;
  logic [vsws_pkg::CountW-1:0] count_d;
  vsws_pkg::rsp_t              rsp_q;
  vsws_pkg::rsp_t              rsp_d;
  logic                        done_q;
  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        hit_any;
  vsws_pkg::cell_ctrl_t        ctrl;

  vsws_pkg::value_t            cell_data [vsws_pkg::StackDepth];
  logic [vsws_pkg::StackDepth:0] hit_chain;

  // Every cycle can take a new request.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full    = (count_q == vsws_pkg::CountW'(vsws_pkg::StackDepth));
  assign empty   = (count_q == '0);
  assign hit_any = hit_chain[vsws_pkg::StackDepth];

  // Decode the request into row control, the next count and the result.
  always_comb begin
    count_d                 = count_q;
    ctrl.push               = 1'b0;
    ctrl.pop                = 1'b0;
    ctrl.remove             = 1'b0;
    ctrl.value              = req_i.value;
    rsp_d.result_value      = '0;
    rsp_d.status            = vsws_pkg::StOk;
    rsp_d.found             = 1'b0;
    case (req_i.opcode)
      vsws_pkg::OpPush: begin
        if (full) begin
          rsp_d.status = vsws_pkg::StFull;
        end else begin
          ctrl.push = accept;
          count_d   = count_q + 1'b1;
        end
      end
      vsws_pkg::OpPop: begin
        if (empty) begin
          rsp_d.result_value = '1;
          rsp_d.status       = vsws_pkg::StMiss;
        end else begin
          ctrl.pop           = accept;
          rsp_d.result_value = cell_data[0];
          count_d            = count_q - 1'b1;
        end
      end
      vsws_pkg::OpSearch: begin
        if (hit_any) begin
          rsp_d.found = 1'b1;
        end else begin
          rsp_d.status = vsws_pkg::StMiss;
        end
      end
      vsws_pkg::OpRemove: begin
        if (hit_any) begin
          rsp_d.found = 1'b1;
          ctrl.remove = accept;
          count_d     = count_q - 1'b1;
        end else begin
          rsp_d.status = vsws_pkg::StMiss;
        end
      end
      default: begin
        rsp_d.status = vsws_pkg::StOk;
      end
    endcase
    rsp_d.now_empty = (count_d == '0);
    rsp_d.occupancy = vsws_pkg::OccW'(count_d);
  end

  // Row of cells; cell 0 holds the top entry.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < vsws_pkg::StackDepth; i++) begin : g_cell
    vsws_pkg::value_t above;
    vsws_pkg::value_t below;
    logic             live;

    if (i == 0) begin : g_top
      assign above = req_i.value;
    end else begin : g_inner_above
      assign above = cell_data[i-1];
    end

    if (i == vsws_pkg::StackDepth - 1) begin : g_bottom
      assign below = cell_data[i];
    end else begin : g_inner_below
      assign below = cell_data[i+1];
    end

    assign live = (count_q > vsws_pkg::CountW'(i));

    vsws_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .live_i       (live),
      .above_data_i (above),
      .below_data_i (below),
      .hit_above_i  (hit_chain[i]),
      .hit_o        (hit_chain[i+1]),
      .data_o       (cell_data[i])
    );
  end

  // Entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload, loaded on each transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks on the control path.
  `VSWS_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= vsws_pkg::CountW'(vsws_pkg::StackDepth), "entry count beyond depth")
  `VSWS_ASSERT(a_done_follows, accept |=> done_o, "result strobe missing after transfer")
  `VSWS_ASSERT(a_no_spurious, !accept |=> !done_o, "result strobe without transfer")
  `VSWS_ASSERT(a_full_status, done_o && rsp_o.status == vsws_pkg::StFull |-> full, "full status while not full")
  `VSWS_ASSERT(a_pop_count, accept && req_i.opcode == vsws_pkg::OpPop && !empty |=> count_q == $past(count_q) - 1'b1, "pop did not drop count")

endmodule
